// File: src/uirc_pkg.sv
// package: beat types, operation and status codes, counter indices for the uplink reconciler
package uirc_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int NUM_COUNTERS    = 6;
    localparam int VALUE_WIDTH     = 32;
    localparam int SEL_WIDTH       = 3;

    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_READY = 2'd1;
    localparam logic [1:0] OP_POLL  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [2:0] EV_CONV_START = 3'd0;
    localparam logic [2:0] EV_TALK_START = 3'd1;
    localparam logic [2:0] EV_TALK_STOP  = 3'd2;
    localparam logic [2:0] EV_CONV_END   = 3'd3;

    localparam logic [1:0] ANS_ACCEPTED     = 2'd0;
    localparam logic [1:0] ANS_BACKPRESSURE = 2'd1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_INVALID      = 2'd1;
    localparam logic [1:0] ST_BACKPRESSURE = 2'd2;
    localparam logic [1:0] ST_FAILED       = 2'd3;

    localparam logic MODE_FULL_DUPLEX = 1'b1;

    localparam int CNT_EDGES        = 0;
    localparam int CNT_READY        = 1;
    localparam int CNT_ACCEPTED     = 2;
    localparam int CNT_BACKPRESSURE = 3;
    localparam int CNT_FAILURES     = 4;
    localparam int CNT_RESETS       = 5;

    typedef struct packed {
        logic [1:0]           op;
        logic [2:0]           event_kind;
        logic                 ready_value;
        logic [1:0]           sink_answer;
        logic [7:0]           sink_error_code;
        logic [SEL_WIDTH-1:0] counter_select;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [7:0]             failure_code;
        logic                   issue_command;
        logic                   command_value;
        logic                   reset_playback;
        logic                   desired_active;
        logic                   media_is_ready;
        logic                   applied_level;
        logic                   command_waiting;
        logic                   has_failed;
        logic [VALUE_WIDTH-1:0] counter_value;
    } out_beat_t;

    typedef logic [NUM_COUNTERS-1:0] bump_t;

endpackage

// File: src/uirc_counters.sv
// six saturating event counters with a selected read port
module uirc_counters #(
    parameter int COUNT_WIDTH = uirc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  uirc_pkg::bump_t                     bump,
    input  logic [uirc_pkg::SEL_WIDTH-1:0]      sel,
    output logic [uirc_pkg::VALUE_WIDTH-1:0]    rd_value
);

    localparam int VW = uirc_pkg::VALUE_WIDTH;

    logic [COUNT_WIDTH-1:0] cnt_reg [uirc_pkg::NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] cnt_sel;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < uirc_pkg::NUM_COUNTERS; i++) begin
            if (!aresetn) begin
                cnt_reg[i] <= '0;
            end else if (bump[i] && (cnt_reg[i] != {COUNT_WIDTH{1'b1}})) begin
                cnt_reg[i] <= cnt_reg[i] + 1'b1;
            end
        end
    end

    always_comb begin
        if (32'(sel) < 32'(uirc_pkg::NUM_COUNTERS)) begin
            cnt_sel = cnt_reg[sel];
        end else begin
            cnt_sel = '0;
        end
    end

    assign rd_value = VW'(cnt_sel);

endmodule

// File: src/uirc_core.sv
// intent, readiness and applied-level flags with the per-beat decision logic
module uirc_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic                              audio_mode,
    input  uirc_pkg::in_beat_t                in_beat,
    input  logic [uirc_pkg::VALUE_WIDTH-1:0]  cnt_value,
    output uirc_pkg::out_beat_t               out_beat,
    output uirc_pkg::bump_t                   bump
);

    logic       desired_flag_reg, desired_flag_next;
    logic       ready_flag_reg, ready_flag_next;
    logic       applied_flag_reg, applied_flag_next;
    logic       pending_flag_reg, pending_flag_next;
    logic       failed_flag_reg, failed_flag_next;
    logic [7:0] stored_error_reg, stored_error_next;

    logic       ev_valid, ev_sets, ev_level, ev_rst;
    logic [1:0] status;
    logic       issue, cmd, pulse;
    logic [uirc_pkg::VALUE_WIDTH-1:0] cval;
    uirc_pkg::bump_t bump_vec;

    always_comb begin
        ev_valid = 1'b1;
        ev_sets  = 1'b0;
        ev_level = 1'b0;
        ev_rst   = 1'b0;
        case (in_beat.event_kind)
            uirc_pkg::EV_CONV_START: begin
                if (audio_mode == uirc_pkg::MODE_FULL_DUPLEX) begin
                    ev_sets  = 1'b1;
                    ev_level = 1'b1;
                end
            end
            uirc_pkg::EV_TALK_START: begin
                if (audio_mode == uirc_pkg::MODE_FULL_DUPLEX) begin
                    ev_valid = 1'b0;
                end else begin
                    ev_sets  = 1'b1;
                    ev_level = 1'b1;
                    ev_rst   = 1'b1;
                end
            end
            uirc_pkg::EV_TALK_STOP: begin
                if (audio_mode == uirc_pkg::MODE_FULL_DUPLEX) begin
                    ev_valid = 1'b0;
                end else begin
                    ev_sets = 1'b1;
                end
            end
            uirc_pkg::EV_CONV_END: begin
                ev_sets = 1'b1;
                ev_rst  = 1'b1;
            end
            default: begin
                ev_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        desired_flag_next = desired_flag_reg;
        ready_flag_next   = ready_flag_reg;
        applied_flag_next = applied_flag_reg;
        pending_flag_next = pending_flag_reg;
        failed_flag_next  = failed_flag_reg;
        stored_error_next = stored_error_reg;
        status   = uirc_pkg::ST_OK;
        issue    = 1'b0;
        cmd      = 1'b0;
        pulse    = 1'b0;
        cval     = '0;
        bump_vec = '0;
        case (in_beat.op)
            uirc_pkg::OP_EVENT: begin
                if (!ev_valid) begin
                    status = uirc_pkg::ST_INVALID;
                end else begin
                    bump_vec[uirc_pkg::CNT_EDGES] = 1'b1;
                    if (ev_rst) begin
                        pulse = 1'b1;
                        bump_vec[uirc_pkg::CNT_RESETS] = 1'b1;
                    end
                    if (ev_sets) begin
                        desired_flag_next = ev_level;
                        pending_flag_next = applied_flag_reg != (ev_level & ready_flag_reg);
                    end
                    if (failed_flag_reg && ev_level) begin
                        status = uirc_pkg::ST_FAILED;
                    end
                end
            end
            uirc_pkg::OP_READY: begin
                if (ready_flag_reg != in_beat.ready_value) begin
                    ready_flag_next = in_beat.ready_value;
                    bump_vec[uirc_pkg::CNT_READY] = 1'b1;
                    pending_flag_next =
                        applied_flag_reg != (desired_flag_reg & in_beat.ready_value);
                end
            end
            uirc_pkg::OP_POLL: begin
                if (failed_flag_reg) begin
                    status = uirc_pkg::ST_FAILED;
                end else if (pending_flag_reg) begin
                    issue = 1'b1;
                    cmd   = desired_flag_reg & ready_flag_reg;
                    case (in_beat.sink_answer)
                        uirc_pkg::ANS_ACCEPTED: begin
                            bump_vec[uirc_pkg::CNT_ACCEPTED] = 1'b1;
                            applied_flag_next = cmd;
                            pending_flag_next = 1'b0;
                        end
                        uirc_pkg::ANS_BACKPRESSURE: begin
                            bump_vec[uirc_pkg::CNT_BACKPRESSURE] = 1'b1;
                            status = uirc_pkg::ST_BACKPRESSURE;
                        end
                        default: begin
                            bump_vec[uirc_pkg::CNT_FAILURES] = 1'b1;
                            failed_flag_next  = 1'b1;
                            stored_error_next = in_beat.sink_error_code;
                            status = uirc_pkg::ST_FAILED;
                        end
                    endcase
                end
            end
            default: begin
                cval = cnt_value;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desired_flag_reg <= 1'b0;
            ready_flag_reg   <= 1'b0;
            applied_flag_reg <= 1'b0;
            pending_flag_reg <= 1'b0;
            failed_flag_reg  <= 1'b0;
            stored_error_reg <= '0;
        end else if (adv) begin
            desired_flag_reg <= desired_flag_next;
            ready_flag_reg   <= ready_flag_next;
            applied_flag_reg <= applied_flag_next;
            pending_flag_reg <= pending_flag_next;
            failed_flag_reg  <= failed_flag_next;
            stored_error_reg <= stored_error_next;
        end
    end

    assign bump = adv ? bump_vec : '0;

    always_comb begin
        out_beat.status          = status;
        out_beat.failure_code    = stored_error_next;
        out_beat.issue_command   = issue;
        out_beat.command_value   = cmd;
        out_beat.reset_playback  = pulse;
        out_beat.desired_active  = desired_flag_next;
        out_beat.media_is_ready  = ready_flag_next;
        out_beat.applied_level   = applied_flag_next;
        out_beat.command_waiting = pending_flag_next;
        out_beat.has_failed      = failed_flag_next;
        out_beat.counter_value   = cval;
    end

    // pending always mirrors the mismatch between applied and wanted level
    a_pending_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_flag_reg == (applied_flag_reg != (desired_flag_reg & ready_flag_reg)))
        else $error("pending flag out of step with applied and wanted level");

    a_failure_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_flag_reg |=> failed_flag_reg)
        else $error("sticky failure cleared without reset");

    a_error_only_when_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        !failed_flag_reg |-> (stored_error_reg == 8'd0))
        else $error("error code stored without failure");

    a_no_bump_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |-> (bump == '0))
        else $error("counter bumped without a beat");

endmodule

// File: src/uplink_intent_reconciler_unit.sv
// top level: input register, decision core, event counters and result register
// path: an accepted beat is held in the input register, then its result is loaded into the result register
// throughput: one beat per cycle; the input and result registers advance together
// whenever the result register is empty or being taken
// reset: synchronous active-low aresetn clears all flags, counters, audio_mode and
// both register valids; no clearing pass
module uplink_intent_reconciler_unit #(
    parameter int COUNT_WIDTH = uirc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  uirc_pkg::in_beat_t   s_beat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output uirc_pkg::out_beat_t  m_beat
);

    logic                audio_mode_reg;
    logic                in_valid_reg;
    uirc_pkg::in_beat_t  in_beat_reg;
    logic                out_valid_reg;
    uirc_pkg::out_beat_t out_beat_reg;

    logic                out_free;
    logic                adv;
    uirc_pkg::out_beat_t core_beat;
    uirc_pkg::bump_t     bump;
    logic [uirc_pkg::VALUE_WIDTH-1:0] cnt_value;

    assign out_free = !out_valid_reg || m_ready;
    assign adv      = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            audio_mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (out_free) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_beat_reg <= core_beat;
        end
    end

    uirc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .audio_mode (audio_mode_reg),
        .in_beat    (in_beat_reg),
        .cnt_value  (cnt_value),
        .out_beat   (core_beat),
        .bump       (bump)
    );

    uirc_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bump     (bump),
        .sel      (in_beat_reg.counter_select),
        .rd_value (cnt_value)
    );

    assign m_valid = out_valid_reg;
    assign m_beat  = out_beat_reg;

endmodule
